### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/lil_pkg.sv
package lil_pkg;

  localparam int MAX_LINES   = 4096;
  localparam int OFFSET_BITS = 20;

  localparam int IDX_W      = $clog2(MAX_LINES);
  localparam int CNT_W      = $clog2(MAX_LINES + 1);
  localparam int LINE_NUM_W = 13;
  localparam int COL_W      = 21;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [OFFSET_BITS-1:0] wr_data;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
  } ram_ctrl_t;

endpackage

### rtl/line_index_and_locator_top.sv
// Line-start index and offset locator.
// The input channel (in_valid/in_ready) carries opcode, text_byte and query_offset.
// A clear transaction resets the index to a single line starting at offset 0; an
// append transaction takes one text byte and, for a newline, records the next byte
// position as a new line start. Neither produces a result.
// A query transaction searches the line-start table by bisection, one memory probe
// per cycle on the single read port of the index RAM, and then registers the
// result. The block is not ready meanwhile and takes the next transaction from
// the cycle in which the result appears.
// The result (line_number, column_number, overflow) sits in an output register on
// the out_valid/out_ready channel. Appends and clears are still accepted while it
// waits; a further query completes its search and then holds until the receiver
// has taken the pending result.
// Newlines beyond the table capacity are dropped and set the sticky overflow flag.
// Reset empties the index to one line at offset 0 and clears the overflow flag and
// the byte position; no clearing pass over the RAM is needed, as line 0 always
// starts at zero and only data read from recorded entries is ever used.
module line_index_and_locator_top
  import lil_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             opcode,
  input  logic [7:0]             text_byte,
  input  logic [OFFSET_BITS-1:0] query_offset,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [LINE_NUM_W-1:0]  line_number,
  output logic [COL_W-1:0]       column_number,
  output logic                   overflow
);

`include "assert_macros.svh"

  state_t                 state, state_next;
  logic [CNT_W-1:0]       line_total, line_total_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic                   table_overflowed, table_overflowed_next;
  logic [IDX_W-1:0]       lo, lo_next;
  logic [CNT_W-1:0]       hi, hi_next;
  logic [IDX_W-1:0]       mid, mid_next;
  logic [OFFSET_BITS-1:0] lo_start, lo_start_next;
  logic [OFFSET_BITS-1:0] off, off_next;
  logic                   out_valid_next;
  logic [LINE_NUM_W-1:0]  line_number_next;
  logic [COL_W-1:0]       column_number_next;
  logic                   overflow_next;

  ram_ctrl_t              ram_ctrl;
  logic [OFFSET_BITS-1:0] rd_data;
  logic [CNT_W-1:0]       span;

  logic                   window_open;
  logic                   total_in_range;
  logic                   table_full;

  lil_index_ram u_index_ram (
    .clk     (clk),
    .ctrl    (ram_ctrl),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      line_total       <= CNT_W'(1);
      byte_position    <= '0;
      table_overflowed <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      line_total       <= line_total_next;
      byte_position    <= byte_position_next;
      table_overflowed <= table_overflowed_next;
      out_valid        <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lo            <= lo_next;
    hi            <= hi_next;
    mid           <= mid_next;
    lo_start      <= lo_start_next;
    off           <= off_next;
    line_number   <= line_number_next;
    column_number <= column_number_next;
    overflow      <= overflow_next;
  end

  always_comb begin
    state_next            = state;
    line_total_next       = line_total;
    byte_position_next    = byte_position;
    table_overflowed_next = table_overflowed;
    lo_next               = lo;
    hi_next               = hi;
    mid_next              = mid;
    lo_start_next         = lo_start;
    off_next              = off;
    out_valid_next        = out_valid && !out_ready;
    line_number_next      = line_number;
    column_number_next    = column_number;
    overflow_next         = overflow;
    in_ready              = 1'b0;
    span                  = '0;
    ram_ctrl              = '0;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (opcode)
            OP_CLEAR: begin
              line_total_next       = CNT_W'(1);
              byte_position_next    = '0;
              table_overflowed_next = 1'b0;
            end
            OP_APPEND: begin
              byte_position_next = byte_position + OFFSET_BITS'(1);
              if (text_byte == NEWLINE_BYTE) begin
                if (line_total != CNT_W'(MAX_LINES)) begin
                  ram_ctrl.wr_en   = 1'b1;
                  ram_ctrl.wr_addr = IDX_W'(line_total);
                  ram_ctrl.wr_data = byte_position + OFFSET_BITS'(1);
                  line_total_next  = line_total + CNT_W'(1);
                end else begin
                  table_overflowed_next = 1'b1;
                end
              end
            end
            OP_QUERY: begin
              lo_next          = '0;
              hi_next          = line_total;
              lo_start_next    = '0;
              off_next         = query_offset;
              mid_next         = IDX_W'(line_total >> 1);
              ram_ctrl.rd_en   = 1'b1;
              ram_ctrl.rd_addr = IDX_W'(line_total >> 1);
              state_next = (line_total == CNT_W'(1)) ? ST_FINISH : ST_SEARCH;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SEARCH: begin
        if (rd_data > off) begin
          hi_next = CNT_W'(mid);
        end else begin
          lo_next       = mid;
          lo_start_next = rd_data;
        end
        span = hi_next - CNT_W'(lo_next);
        if (span > CNT_W'(1)) begin
          mid_next         = IDX_W'(CNT_W'(lo_next) + (span >> 1));
          ram_ctrl.rd_en   = 1'b1;
          ram_ctrl.rd_addr = IDX_W'(CNT_W'(lo_next) + (span >> 1));
        end else begin
          state_next = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          out_valid_next     = 1'b1;
          line_number_next   = LINE_NUM_W'(CNT_W'(lo) + CNT_W'(1));
          column_number_next = COL_W'(off) - COL_W'(lo_start) + COL_W'(1);
          overflow_next      = table_overflowed;
          state_next         = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign window_open    = (CNT_W'(lo) + CNT_W'(1)) < hi;
  assign total_in_range = (line_total != '0) && (line_total <= CNT_W'(MAX_LINES));
  assign table_full     = line_total == CNT_W'(MAX_LINES);

  `ASSERT_IMPLIES(a_search_bounds, clk, rst, state == ST_SEARCH, window_open, "Empty window.")
  `ASSERT_ALWAYS(a_total_range, clk, rst, total_in_range, "Line total out of range.")
  `ASSERT_IMPLIES(a_overflow_full, clk, rst, table_overflowed, table_full, "Table not full.")
  `ASSERT_IMPLIES(a_result, clk, rst, $rose(out_valid), $past(state) == ST_FINISH, "Stray result.")

endmodule

### rtl/lil_index_ram.sv
module lil_index_ram
  import lil_pkg::*;
(
  input  logic                   clk,
  input  ram_ctrl_t              ctrl,
  output logic [OFFSET_BITS-1:0] rd_data
);

  logic [OFFSET_BITS-1:0] mem [MAX_LINES];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= mem[ctrl.rd_addr];
    end
  end

endmodule
